/* rtl/mlpq_pkg.sv */
// ----------------------------------------------------------------------------
// mlpq_pkg: shared definitions of the multilevel priority ready queue
// Sizes, operation codes, cell commands and the entry type of the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mlpq_pkg;

  localparam int NUM_PROCS  = 32;
  localparam int NUM_LEVELS = 4;

  localparam int KIND_W = 2;
  localparam int ID_W   = 5;
  localparam int LVL_W  = 2;
  localparam int IDX_W  = $clog2(NUM_PROCS);
  localparam int CNT_W  = $clog2(NUM_PROCS + 1);

  localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REM  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PEEK = 2'd3;

  typedef logic [2:0] cell_op_t;

  localparam cell_op_t CELL_NOP     = 3'd0;
  localparam cell_op_t CELL_INSERT  = 3'd1;
  localparam cell_op_t CELL_SHIFT   = 3'd2;
  localparam cell_op_t CELL_MARK    = 3'd3;
  localparam cell_op_t CELL_COMPACT = 3'd4;

  typedef struct packed {
    logic             valid;
    logic             hole;
    logic [ID_W-1:0]  id;
    logic [LVL_W-1:0] level;
  } entry_t;

  typedef struct packed {
    cell_op_t         op;
    logic [ID_W-1:0]  id;
    logic [LVL_W-1:0] level;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/mlpq_if.sv */
// ----------------------------------------------------------------------------
// mlpq_if: request and response channels of the ready queue
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mlpq_req_if;
  logic                       valid;
  logic                       ready;
  logic [mlpq_pkg::KIND_W-1:0] kind;
  logic [mlpq_pkg::ID_W-1:0]   proc_id;
  logic [mlpq_pkg::LVL_W-1:0]  prio_level;

  modport source (output valid, kind, proc_id, prio_level, input ready);
  modport sink (input valid, kind, proc_id, prio_level, output ready);
endinterface

interface mlpq_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic [mlpq_pkg::ID_W-1:0] proc_out;
  logic                     all_empty;

  modport source (output valid, hit, proc_out, all_empty, input ready);
  modport sink (input valid, hit, proc_out, all_empty, output ready);
endinterface

`default_nettype wire

/* rtl/mlpq_cell.sv */
// ----------------------------------------------------------------------------
// mlpq_cell: one slot of the sorted queue chain
// Holds one queued id with its level and trades it with its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlpq_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mlpq_pkg::cell_cmd_t cmd,
  input  wire mlpq_pkg::entry_t    left,
  input  wire mlpq_pkg::entry_t    right,
  output mlpq_pkg::entry_t         ent
);

  logic                       valid;
  logic                       hole;
  logic [mlpq_pkg::ID_W-1:0]  id;
  logic [mlpq_pkg::LVL_W-1:0] level;

  logic                       valid_next;
  logic                       hole_next;
  logic [mlpq_pkg::ID_W-1:0]  id_next;
  logic [mlpq_pkg::LVL_W-1:0] level_next;
  logic                       self_stays;
  logic                       left_stays;

  assign self_stays = valid && (level <= cmd.level);
  assign left_stays = left.valid && (left.level <= cmd.level);

  always_comb begin
    valid_next = valid;
    hole_next  = hole;
    id_next    = id;
    level_next = level;
    case (cmd.op)
      mlpq_pkg::CELL_INSERT: begin
        if (!self_stays) begin
          if (left_stays) begin
            valid_next = 1'b1;
            id_next    = cmd.id;
            level_next = cmd.level;
          end else begin
            valid_next = left.valid;
            id_next    = left.id;
            level_next = left.level;
          end
          hole_next = 1'b0;
        end
      end
      mlpq_pkg::CELL_SHIFT: begin
        valid_next = right.valid;
        hole_next  = 1'b0;
        id_next    = right.id;
        level_next = right.level;
      end
      mlpq_pkg::CELL_MARK: begin
        if (valid && (id == cmd.id) && (level == cmd.level)) begin
          valid_next = 1'b0;
          hole_next  = 1'b1;
        end
      end
      mlpq_pkg::CELL_COMPACT: begin
        if (hole) begin
          valid_next = right.valid;
          hole_next  = 1'b0;
          id_next    = right.id;
          level_next = right.level;
        end else if (left.hole) begin
          valid_next = 1'b0;
          hole_next  = valid;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hole  <= 1'b0;
    end else begin
      valid <= valid_next;
      hole  <= hole_next;
    end
  end

  always_ff @(posedge clk) begin
    id    <= id_next;
    level <= level_next;
  end

  assign ent = '{valid: valid, hole: hole, id: id, level: level};

endmodule

`default_nettype wire

/* rtl/mlpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mlpq_ctrl: operation sequencer of the ready queue
// Takes requests, keeps the per-id membership and level, drives the cell
// chain and forms the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlpq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  mlpq_req_if.sink                 req,
  mlpq_rsp_if.source               rsp,
  input  wire mlpq_pkg::entry_t     head,
  output mlpq_pkg::cell_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_EXEC    = 2'd1;
  localparam logic [1:0] ST_COMPACT = 2'd2;

  logic [1:0]                       state;
  logic [1:0]                       state_next;
  logic [mlpq_pkg::KIND_W-1:0]      kind;
  logic [mlpq_pkg::ID_W-1:0]        id;
  logic [mlpq_pkg::LVL_W-1:0]       lvl;
  logic [mlpq_pkg::LVL_W-1:0]       lvl_stored;
  logic [mlpq_pkg::NUM_PROCS-1:0]   member;
  logic [mlpq_pkg::LVL_W-1:0]       lvl_of [mlpq_pkg::NUM_PROCS];
  logic [mlpq_pkg::CNT_W-1:0]       count;
  logic [mlpq_pkg::CNT_W-1:0]       count_next;
  logic [mlpq_pkg::IDX_W-1:0]       cmp_cnt;
  logic [mlpq_pkg::IDX_W-1:0]       cmp_cnt_next;

  logic                             out_valid;
  logic                             out_hit;
  logic [mlpq_pkg::ID_W-1:0]        out_proc;
  logic                             out_empty;

  logic                             go;
  logic                             r_hit;
  logic [mlpq_pkg::ID_W-1:0]        r_proc;
  logic                             set_en;
  logic                             clr_en;
  logic [mlpq_pkg::IDX_W-1:0]       clr_idx;
  logic [mlpq_pkg::IDX_W-1:0]       idx;
  logic                             args_ok;

  assign idx     = id[mlpq_pkg::IDX_W-1:0];
  assign args_ok = (32'(id) < 32'(mlpq_pkg::NUM_PROCS)) &&
                   (32'(lvl) < 32'(mlpq_pkg::NUM_LEVELS));

  assign req.ready     = (state == ST_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.hit       = out_hit;
  assign rsp.proc_out  = out_proc;
  assign rsp.all_empty = out_empty;

  always_comb begin
    state_next   = state;
    cmd          = '{op: mlpq_pkg::CELL_NOP, id: id, level: lvl};
    go           = 1'b0;
    r_hit        = 1'b0;
    r_proc       = '0;
    count_next   = count;
    cmp_cnt_next = cmp_cnt;
    set_en       = 1'b0;
    clr_en       = 1'b0;
    clr_idx      = idx;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid || rsp.ready) begin
          go         = 1'b1;
          state_next = ST_IDLE;
          case (kind)
            mlpq_pkg::KIND_ENQ: begin
              if (args_ok && !member[idx]) begin
                r_hit      = 1'b1;
                set_en     = 1'b1;
                count_next = count + mlpq_pkg::CNT_W'(1);
                cmd.op     = mlpq_pkg::CELL_INSERT;
              end
            end
            mlpq_pkg::KIND_DEQ: begin
              if (head.valid) begin
                r_hit      = 1'b1;
                r_proc     = head.id;
                clr_en     = 1'b1;
                clr_idx    = head.id[mlpq_pkg::IDX_W-1:0];
                count_next = count - mlpq_pkg::CNT_W'(1);
                cmd.op     = mlpq_pkg::CELL_SHIFT;
              end
            end
            mlpq_pkg::KIND_REM: begin
              if (args_ok && member[idx] && (lvl_stored == lvl)) begin
                r_hit        = 1'b1;
                r_proc       = id;
                clr_en       = 1'b1;
                count_next   = count - mlpq_pkg::CNT_W'(1);
                cmd.op       = mlpq_pkg::CELL_MARK;
                cmp_cnt_next = mlpq_pkg::IDX_W'(mlpq_pkg::NUM_PROCS - 1);
                state_next   = ST_COMPACT;
              end
            end
            mlpq_pkg::KIND_PEEK: begin
              if (head.valid) begin
                r_hit  = 1'b1;
                r_proc = head.id;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_COMPACT: begin
        cmd.op       = mlpq_pkg::CELL_COMPACT;
        cmp_cnt_next = cmp_cnt - mlpq_pkg::IDX_W'(1);
        if (cmp_cnt == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      member    <= '0;
      count     <= '0;
      cmp_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      cmp_cnt <= cmp_cnt_next;
      if (set_en) begin
        member[idx] <= 1'b1;
      end
      if (clr_en) begin
        member[clr_idx] <= 1'b0;
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      kind       <= req.kind;
      id         <= req.proc_id;
      lvl        <= req.prio_level;
      lvl_stored <= lvl_of[req.proc_id[mlpq_pkg::IDX_W-1:0]];
    end
    if (set_en) begin
      lvl_of[idx] <= lvl;
    end
    if (go) begin
      out_hit   <= r_hit;
      out_proc  <= r_proc;
      out_empty <= (count_next == '0);
    end
  end

endmodule

`default_nettype wire

/* rtl/multilevel_priority_ready_queue.sv */
// ----------------------------------------------------------------------------
// multilevel_priority_ready_queue: ready queue of process ids by priority
// Enqueue, dequeue, peek and remove over four FIFO priority levels.
// ----------------------------------------------------------------------------
// The queue is a chain of NUM_PROCS cells kept sorted by level, oldest first
// within a level, so the head of the chain is always the next id to run.
// Each item is accepted while the sequencer is idle; in the EXEC state the
// chain updates and the response register loads, and the request side is
// then ready again. EXEC waits while an earlier result is not yet taken. A
// remove that finds its id leaves a gap in the chain that moves one cell per
// cycle toward the end, so such a remove keeps the request side busy through
// the COMPACT state until the gap has passed the last cell. The response
// register frees the request side while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_priority_ready_queue (
  input  wire logic  clk,
  input  wire logic  rst,
  mlpq_req_if.sink   req,
  mlpq_rsp_if.source rsp
);

  mlpq_pkg::entry_t    ent [mlpq_pkg::NUM_PROCS];
  mlpq_pkg::cell_cmd_t cmd;

  localparam mlpq_pkg::entry_t FRONT = '{valid: 1'b1, hole: 1'b0, id: '0, level: '0};
  localparam mlpq_pkg::entry_t BACK  = '{valid: 1'b0, hole: 1'b0, id: '0, level: '0};

  mlpq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .head (ent[0]),
    .cmd  (cmd)
  );

  for (genvar i = 0; i < mlpq_pkg::NUM_PROCS; i++) begin : g_cell
    mlpq_pkg::entry_t left;
    mlpq_pkg::entry_t right;

    if (i == 0) begin : g_first
      assign left = FRONT;
    end else begin : g_mid_l
      assign left = ent[i-1];
    end

    if (i == mlpq_pkg::NUM_PROCS - 1) begin : g_last
      assign right = BACK;
    end else begin : g_mid_r
      assign right = ent[i+1];
    end

    mlpq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  (left),
      .right (right),
      .ent   (ent[i])
    );
  end

endmodule

`default_nettype wire

/* rtl/mlpq_checker.sv */
// ----------------------------------------------------------------------------
// mlpq_checker: port-level checks of the ready queue
// Watches the request and response channels and flags broken sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlpq_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      req_valid,
  input wire logic                      req_ready,
  input wire logic                      rsp_valid,
  input wire logic                      rsp_ready,
  input wire logic                      rsp_hit,
  input wire logic [mlpq_pkg::ID_W-1:0] rsp_proc_out,
  input wire logic                      rsp_all_empty
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
    $stable(rsp_proc_out) && $stable(rsp_all_empty))
    else $error("response changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_hit |-> rsp_proc_out == '0)
    else $error("process id reported without a hit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous item is in work");

  a_rsp_from_req: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
    else $error("response without a matching request item");

endmodule

bind multilevel_priority_ready_queue mlpq_checker u_mlpq_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_hit       (rsp.hit),
  .rsp_proc_out  (rsp.proc_out),
  .rsp_all_empty (rsp.all_empty)
);

`default_nettype wire
